[rtl/core/fssynth_pkg.sv]
// Shared types, constants, sine table builder and microprogram of the harmonic synthesiser.
package fssynth_pkg;

    localparam int HIGHEST_HARMONIC = 7;
    localparam int PHASE_W          = 32;
    localparam int COEFF_W          = 16;
    localparam int SINE_DEPTH       = 1024;

    localparam int COEFF_COUNT = 2 * (HIGHEST_HARMONIC + 1);
    localparam int COEFF_IDX_W = $clog2(COEFF_COUNT);
    localparam int K_W         = $clog2(HIGHEST_HARMONIC + 1);
    localparam int ROM_AW      = $clog2(SINE_DEPTH);
    localparam int SINE_W      = 16;
    localparam int PROD_W      = SINE_W + COEFF_W;
    localparam int ACC_W       = PROD_W + COEFF_IDX_W;
    localparam int FRAC_SHIFT  = COEFF_W - 1;
    localparam int CHAN_W      = 2;
    localparam int DRIVE_W     = 21;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [K_W-1:0]         K_LAST   = K_W'(HIGHEST_HARMONIC);
    localparam logic [COEFF_IDX_W-1:0] COS_BASE = COEFF_IDX_W'(HIGHEST_HARMONIC + 1);
    localparam logic [PHASE_W-1:0]     QUARTER_TURN = PHASE_W'(1) << (PHASE_W - 2);

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // Operation codes carried in tuser
    localparam logic OP_TICK        = 1'b0;
    localparam logic OP_COEFF_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_PHASE_STEP  = 1'b0;
    localparam logic CFG_DAC_CHANNEL = 1'b1;

    // Microprogram step addresses
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] UPC_IDLE     = 3'd0;
    localparam logic [UPC_W-1:0] UPC_SIN0     = 3'd1;
    localparam logic [UPC_W-1:0] UPC_COS0     = 3'd2;
    localparam logic [UPC_W-1:0] UPC_LOOP_SIN = 3'd3;
    localparam logic [UPC_W-1:0] UPC_LOOP_COS = 3'd4;
    localparam logic [UPC_W-1:0] UPC_DRAIN0   = 3'd5;
    localparam logic [UPC_W-1:0] UPC_DRAIN1   = 3'd6;
    localparam logic [UPC_W-1:0] UPC_FINISH   = 3'd7;

    typedef struct packed {
        logic             rd_cos;     // look up cosine slot instead of sine slot
        logic             harm_step;  // move on to the next harmonic
        logic             acc_en;     // add product register into accumulator
        logic             wait_tick;  // hold until a tick transaction arrives
        logic             finish;     // round, saturate and hand over the result
        logic             branch;     // jump to target while harmonics remain
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

    function automatic ucode_t ucode_word(input logic [UPC_W-1:0] upc);
        ucode_t w;
        w = '0;
        case (upc)
            UPC_IDLE: begin
                w.wait_tick = 1'b1;
            end
            UPC_SIN0: begin
                w.rd_cos = 1'b0;
            end
            UPC_COS0: begin
                w.rd_cos    = 1'b1;
                w.harm_step = 1'b1;
            end
            UPC_LOOP_SIN: begin
                w.acc_en = 1'b1;
            end
            UPC_LOOP_COS: begin
                w.rd_cos    = 1'b1;
                w.acc_en    = 1'b1;
                w.harm_step = 1'b1;
                w.branch    = 1'b1;
                w.target    = UPC_LOOP_SIN;
            end
            UPC_DRAIN0: begin
                w.acc_en = 1'b1;
            end
            UPC_DRAIN1: begin
                w.acc_en = 1'b1;
            end
            UPC_FINISH: begin
                w.finish = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // Truncating unsigned division for the table builder, shift and subtract
    function automatic longint unsigned div_trunc(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sine table, Q1.15: quarter-wave reflection and an odd series through x^17
    // on Q2.30 radians, every series product and division truncated; the final scaling rounds.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t         rom;
        longint unsigned   u;
        longint unsigned   r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   mag;
        longint            sum;
        longint unsigned   quad;
        longint unsigned   one_q30;
        longint unsigned   half_pi_q30;
        one_q30     = 64'h0000_0000_4000_0000;
        half_pi_q30 = 64'd1686629713;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            u    = (longint'(i) << 32) / SINE_DEPTH;
            quad = (u >> 30) & 64'd3;
            r    = u & (one_q30 - 64'd1);
            if (quad[0]) begin
                r = one_q30 - r;
            end
            x    = (r * half_pi_q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 3; n <= 17; n += 2) begin
                term = div_trunc((term * x2) >> 30, longint'((n - 1) * n));
                if (((n >> 1) & 1) != 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(one_q30)) begin
                sum = longint'(one_q30);
            end
            mag = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (quad >= 64'd2) begin
                rom[i] = -SINE_W'(mag);
            end else begin
                rom[i] = SINE_W'(mag);
            end
        end
        return rom;
    endfunction

endpackage

[rtl/core/fourier_series_waveform_synth_core.sv]
// Harmonic Fourier-series waveform synthesiser: microcoded sequencer over one ROM and one MAC.
// Tick: the program walks all harmonics, then FINISH registers the result; input waits for idle.
// Coefficient write: no result, and the core stays idle; the next item may follow at once.
// Rate is set by the single sine ROM read port: one sine and one cosine lookup per harmonic.
// A finished result waits in the output register; the sequencer only stalls if it is still full.
// Synchronous active-low reset clears phase, coefficients, configuration and output valid.
module fourier_series_waveform_synth_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] coeff_index, [19:4] coeff_value, [23:20] zero
    input  logic [fssynth_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] channel, [22:2] drive_value, [23] zero
    output logic [fssynth_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fssynth_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [UPC_W-1:0]              upc_reg, upc_next;
    logic [K_W-1:0]                k_reg;
    logic [PHASE_W-1:0]            ph_reg;
    logic [PHASE_W-1:0]            phase_accum_reg;
    logic [PHASE_W-1:0]            phase_step_reg;
    logic [CHAN_W-1:0]             dac_channel_reg;
    logic signed [COEFF_W-1:0]     coeff_table_reg [COEFF_COUNT];
    logic signed [SINE_W-1:0]      rom_q_reg;
    logic signed [COEFF_W-1:0]     coef_q_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic                          m_valid_reg;
    logic [CHAN_W-1:0]             m_channel_reg;
    logic signed [DRIVE_W-1:0]     m_drive_reg;

    ucode_t                        uc;
    logic                          s_fire;
    logic                          tick_fire;
    logic                          out_free;
    logic [PHASE_W-1:0]            rom_phase;
    logic [ROM_AW-1:0]             rom_addr;
    logic [COEFF_IDX_W-1:0]        coef_idx;
    logic [COEFF_IDX_W-1:0]        wr_idx;
    logic signed [ACC_W:0]         acc_round;
    logic signed [ACC_W-FRAC_SHIFT:0] acc_shifted;
    logic signed [DRIVE_W-1:0]     drive_sat;

    always_comb begin
        uc        = ucode_word(upc_reg);
        s_fire    = s_axis_tvalid && s_axis_tready;
        tick_fire = s_fire && (s_axis_tuser == OP_TICK);
        out_free  = !m_valid_reg || m_axis_tready;

        rom_phase = uc.rd_cos ? (ph_reg + QUARTER_TURN) : ph_reg;
        rom_addr  = rom_phase[PHASE_W-1 -: ROM_AW];
        coef_idx  = uc.rd_cos ? (COEFF_IDX_W'(k_reg) + COS_BASE) : COEFF_IDX_W'(k_reg);
        wr_idx    = s_axis_tdata[COEFF_IDX_W-1:0];

        // round half up, floor shift, then saturate
        acc_round   = {acc_reg[ACC_W-1], acc_reg} + ((ACC_W+1)'(1) << (FRAC_SHIFT - 1));
        acc_shifted = acc_round[ACC_W:FRAC_SHIFT];
        if (acc_shifted > (ACC_W-FRAC_SHIFT+1)'(DRIVE_MAX)) begin
            drive_sat = DRIVE_MAX;
        end else if (acc_shifted < (ACC_W-FRAC_SHIFT+1)'(DRIVE_MIN)) begin
            drive_sat = DRIVE_MIN;
        end else begin
            drive_sat = acc_shifted[DRIVE_W-1:0];
        end

        upc_next = upc_reg + UPC_W'(1);
        if (uc.wait_tick) begin
            upc_next = tick_fire ? UPC_SIN0 : UPC_IDLE;
        end else if (uc.branch && (k_reg != K_LAST)) begin
            upc_next = uc.target;
        end else if (uc.finish) begin
            upc_next = out_free ? UPC_IDLE : UPC_FINISH;
        end
    end

    assign s_axis_tready = (upc_reg == UPC_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_drive_reg, m_channel_reg};

    // Sequencer, harmonic walk, phase, configuration and output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg         <= UPC_IDLE;
            k_reg           <= '0;
            ph_reg          <= '0;
            phase_accum_reg <= '0;
            phase_step_reg  <= '0;
            dac_channel_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PHASE_STEP:  phase_step_reg  <= cfg_wdata[PHASE_W-1:0];
                    CFG_DAC_CHANNEL: dac_channel_reg <= cfg_wdata[CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (tick_fire) begin
                k_reg  <= '0;
                ph_reg <= '0;
            end else if (uc.harm_step) begin
                k_reg  <= k_reg + K_W'(1);
                ph_reg <= ph_reg + phase_accum_reg;
            end
            if (uc.finish && out_free) begin
                m_valid_reg     <= 1'b1;
                phase_accum_reg <= phase_accum_reg + phase_step_reg;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Coefficient store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEFF_COUNT; i++) begin
                coeff_table_reg[i] <= '0;
            end
        end else if (s_fire && (s_axis_tuser == OP_COEFF_WRITE)) begin
            coeff_table_reg[wr_idx] <= s_axis_tdata[COEFF_IDX_W +: COEFF_W];
        end
    end

    // Datapath: ROM and coefficient read, multiply, accumulate (free running)
    always_ff @(posedge aclk) begin
        rom_q_reg  <= SINE_ROM[rom_addr];
        coef_q_reg <= coeff_table_reg[coef_idx];
        prod_reg   <= rom_q_reg * coef_q_reg;
        if (tick_fire) begin
            acc_reg <= '0;
        end else if (uc.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (uc.finish && out_free) begin
            m_channel_reg <= dac_channel_reg;
            m_drive_reg   <= drive_sat;
        end
    end

    property p_tick_starts_program;
        @(posedge aclk) disable iff (!aresetn)
            tick_fire |=> (upc_reg == UPC_SIN0);
    endproperty
    a_tick_starts_program: assert property (p_tick_starts_program)
        else $error("tick transaction did not start the microprogram");

    property p_write_stays_idle;
        @(posedge aclk) disable iff (!aresetn)
            (s_fire && (s_axis_tuser == OP_COEFF_WRITE)) |=> (upc_reg == UPC_IDLE);
    endproperty
    a_write_stays_idle: assert property (p_write_stays_idle)
        else $error("coefficient write left the idle step");

    property p_phase_moves_on_finish_only;
        @(posedge aclk) disable iff (!aresetn)
            (upc_reg != UPC_FINISH) |=> $stable(phase_accum_reg);
    endproperty
    a_phase_moves_on_finish_only: assert property (p_phase_moves_on_finish_only)
        else $error("phase accumulator changed outside the finish step");

    property p_result_from_finish;
        @(posedge aclk) disable iff (!aresetn)
            $rose(m_valid_reg) |-> ($past(upc_reg) == UPC_FINISH);
    endproperty
    a_result_from_finish: assert property (p_result_from_finish)
        else $error("result appeared without a finish step");

    property p_finish_after_last_harmonic;
        @(posedge aclk) disable iff (!aresetn)
            (upc_reg == UPC_DRAIN0) |-> (k_reg == K_W'(0)) || (k_reg == K_LAST + K_W'(1));
    endproperty
    a_finish_after_last_harmonic: assert property (p_finish_after_last_harmonic)
        else $error("loop left before all harmonics were visited");

endmodule

[tb/tb.sv]
// Testbench for the harmonic waveform synthesiser core: directed and random streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import fssynth_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 25;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 128;

    typedef struct packed {
        logic [CHAN_W-1:0]         chan;
        logic signed [DRIVE_W-1:0] drive;
    } drive_sample_t;

    // Tracks phase, coefficients and settings; predicts one drive sample per tick.
    class waveform_model;
        logic signed [SINE_W-1:0]  sin_lut [SINE_DEPTH];
        logic signed [COEFF_W-1:0] weights [COEFF_COUNT];
        logic [PHASE_W-1:0]        phase;
        logic [PHASE_W-1:0]        step;
        logic [CHAN_W-1:0]         chan;
        drive_sample_t             pending_drive [$];
        int                        fail_count;

        function new();
            fill_sine_lut();
            phase      = '0;
            step       = '0;
            chan       = '0;
            fail_count = 0;
            foreach (weights[i]) weights[i] = '0;
        endfunction

        // Quarter-wave folding, odd series up to x^17 on Q2.30 radians, series steps truncating, final scaling rounded.
        function void fill_sine_lut();
            longint unsigned turn_frac;
            longint unsigned rem_q30;
            longint unsigned x;
            longint unsigned x_sq;
            longint unsigned term;
            longint unsigned mag;
            longint          series;
            int              quadrant;
            for (int i = 0; i < SINE_DEPTH; i++) begin
                turn_frac = (64'(i) << 32) / SINE_DEPTH;
                quadrant  = int'((turn_frac >> 30) & 64'd3);
                rem_q30   = turn_frac & 64'h3FFF_FFFF;
                if (quadrant[0]) begin
                    rem_q30 = 64'h4000_0000 - rem_q30;
                end
                x      = (rem_q30 * 64'd1686629713) >> 30;
                x_sq   = (x * x) >> 30;
                term   = x;
                series = longint'(x);
                for (int n = 3; n <= 17; n += 2) begin
                    term = ((term * x_sq) >> 30) / 64'((n - 1) * n);
                    if (((n >> 1) & 1) != 0) begin
                        series = series - longint'(term);
                    end else begin
                        series = series + longint'(term);
                    end
                end
                if (series < 0) begin
                    series = 0;
                end
                if (series > 64'sh4000_0000) begin
                    series = 64'sh4000_0000;
                end
                mag = (64'(series) * 64'd32767 + (64'd1 << 29)) >> 30;
                sin_lut[i] = (quadrant >= 2) ? -16'(mag) : 16'(mag);
            end
        endfunction

        function void set_register(logic idx, logic [31:0] data);
            if (idx == CFG_PHASE_STEP) begin
                step = data;
            end else if (idx == CFG_DAC_CHANNEL) begin
                chan = data[CHAN_W-1:0];
            end
        endfunction

        // Called for every accepted input transaction.
        function void take_item(logic op, logic [3:0] idx, logic [15:0] val);
            longint             sum_acc;
            longint             rounded;
            logic [PHASE_W-1:0] harm_ph;
            logic [PHASE_W-1:0] cos_ph;
            drive_sample_t      smp;
            if (op == OP_COEFF_WRITE) begin
                if (idx < COEFF_COUNT) begin
                    weights[idx] = val;
                end
                return;
            end
            sum_acc = 0;
            for (int k = 0; k <= HIGHEST_HARMONIC; k++) begin
                harm_ph = phase * PHASE_W'(k);
                cos_ph  = harm_ph + QUARTER_TURN;
                // table address is the top ten bits of the phase
                sum_acc += longint'(sin_lut[harm_ph[31:22]]) * longint'(weights[k])
                         + longint'(sin_lut[cos_ph[31:22]])
                           * longint'(weights[HIGHEST_HARMONIC + 1 + k]);
            end
            sum_acc += 64'sd1 <<< (COEFF_W - 2);
            rounded  = sum_acc >>> (COEFF_W - 1);
            if (rounded > DRIVE_MAX) begin
                rounded = DRIVE_MAX;
            end
            if (rounded < DRIVE_MIN) begin
                rounded = DRIVE_MIN;
            end
            smp.chan  = chan;
            smp.drive = DRIVE_W'(rounded);
            pending_drive.push_back(smp);
            phase = phase + step;
        endfunction

        function void note_failure(string what);
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] MISMATCH: %s", $time, what);
            end
        endfunction

        function void compare_drive(logic [OUT_TDATA_W-1:0] tdata);
            drive_sample_t smp;
            logic [CHAN_W-1:0]         got_chan;
            logic signed [DRIVE_W-1:0] got_drive;
            got_chan  = tdata[CHAN_W-1:0];
            got_drive = tdata[CHAN_W +: DRIVE_W];
            if (pending_drive.size() == 0) begin
                note_failure($sformatf("unexpected sample chan=%0d drive=%0d",
                                       got_chan, got_drive));
                return;
            end
            smp = pending_drive.pop_front();
            if (got_chan !== smp.chan) begin
                note_failure($sformatf("channel expected %0d got %0d", smp.chan, got_chan));
            end
            if (got_drive !== smp.drive) begin
                note_failure($sformatf("drive expected %0d got %0d", smp.drive, got_drive));
            end
        endfunction

        function int outstanding();
            return pending_drive.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic                   cfg_index     = CFG_PHASE_STEP;
    logic [31:0]            cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = OP_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    waveform_model model = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    int cycle_count     = 0;

    fourier_series_waveform_synth_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off when asked for.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                model.compare_drive(m_axis_tdata);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_register(input logic idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        model.set_register(idx, data);
        @(posedge aclk);
    endtask

    task automatic send_item(input logic op, input logic [3:0] idx, input logic [15:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, val, idx};
        do begin
            @(posedge aclk);
        end while (!(s_axis_tvalid && s_axis_tready));
        model.take_item(op, idx, val);
    endtask

    task automatic send_random_item();
        logic [15:0] val;
        if ($urandom_range(99) < 35) begin
            case ($urandom_range(5))
                0:       val = 16'h7FFF;
                1:       val = 16'h8000;
                default: val = 16'($urandom);
            endcase
            send_item(OP_COEFF_WRITE, 4'($urandom_range(15)), val);
        end else begin
            // fields other than the operation are don't-care on a tick
            send_item(OP_TICK, 4'($urandom), 16'($urandom));
        end
    endtask

    // Sender goes quiet until every outstanding sample is back and the core has settled.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (model.outstanding() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] step_val;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme weights, sign handling, writes between ticks, wrapping steps.
        write_register(CFG_PHASE_STEP, 32'h0400_0000);
        write_register(CFG_DAC_CHANNEL, 32'hFFFF_FFFF);
        send_item(OP_TICK, 4'hF, 16'hFFFF);
        send_item(OP_COEFF_WRITE, 4'd0, 16'h7FFF);
        send_item(OP_COEFF_WRITE, 4'd8, 16'h8000);
        send_item(OP_COEFF_WRITE, 4'd7, 16'h8000);
        send_item(OP_COEFF_WRITE, 4'd15, 16'h7FFF);
        send_item(OP_COEFF_WRITE, 4'd3, 16'h5555);
        send_item(OP_COEFF_WRITE, 4'd12, 16'hAAAA);
        repeat (6) send_item(OP_TICK, 4'd0, 16'h0000);
        drain_results();
        write_register(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_register(CFG_DAC_CHANNEL, 32'h0000_0000);
        repeat (3) send_item(OP_TICK, 4'd0, 16'h0000);
        send_item(OP_COEFF_WRITE, 4'd0, 16'h0000);
        send_item(OP_COEFF_WRITE, 4'd9, 16'hFFFF);
        send_item(OP_COEFF_WRITE, 4'd4, 16'h0001);
        repeat (3) send_item(OP_TICK, 4'd0, 16'h0000);
        drain_results();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 6)
                0:       step_val = 32'h0000_0000;
                1:       step_val = 32'hFFFF_FFFF;
                2:       step_val = 32'h4000_0000;
                3:       step_val = 32'h0000_0001;
                4:       step_val = 32'h8000_0000;
                default: step_val = $urandom;
            endcase
            if (p >= 6 && p != 7) begin
                step_val = $urandom;
            end
            write_register(CFG_PHASE_STEP, step_val);
            write_register(CFG_DAC_CHANNEL, ($urandom & ~32'h3) | 32'(p % 4));
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin sender_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            // long receiver hold-off so the core backs up onto its input
            if (p == 4) begin
                hold_left = 300;
            end
            repeat (PHASE_ITEMS) send_random_item();
            drain_results();
        end

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (model.outstanding() > 0) begin
            model.note_failure("sample never produced");
            void'(model.pending_drive.pop_front());
        end
        if (model.fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/fssynth_pkg.sv
rtl/core/fourier_series_waveform_synth_core.sv
tb/tb.sv
